// File: src/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS + 1);  // holds ROWS while a scroll is pending

  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam logic [7:0] CODE_BS    = 8'd8;
  localparam logic [7:0] CODE_NL    = 8'd10;
  localparam logic [7:0] CODE_CLR   = 8'd11;
  localparam logic [7:0] CODE_SPACE = 8'h20;
  localparam logic [7:0] CODE_UNDER = 8'h5F;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  char_code;
    logic [10:0] cell_addr;
  } in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_UNDER,
    ST_CHECK,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_BLANK,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_PUT,
    MEM_UNDER,
    MEM_ZERO,
    MEM_BLANK,
    MEM_RD_REQ,
    MEM_RD_SCR,
    MEM_WR_SCR
  } mem_op_t;

  typedef enum logic [1:0] {
    CUR_NONE,
    CUR_STEP,
    CUR_HOME,
    CUR_BOTTOM
  } cur_op_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_BOTTOM,
    PTR_INC
  } ptr_op_t;

  typedef struct packed {
    logic    capture;
    mem_op_t mem_op;
    cur_op_t cur_op;
    ptr_op_t ptr_op;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic addr_ok;
    logic is_bs;
    logic is_nl;
    logic is_clr;
    logic col_zero;
    logic row_over;
    logic ptr_scr_last;
    logic ptr_last;
  } sts_t;

endpackage

`default_nettype wire

// File: src/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t      cmd,
  output logic               busy
);

  tcw_pkg::state_t state_r, state_nxt;
  logic            has_req_r, has_req_nxt;

  // Reset lands in the clearing sweep with no request pending.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tcw_pkg::ST_CLEAR;
      has_req_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      has_req_r <= has_req_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    has_req_nxt = has_req_r;
    cmd.capture = 1'b0;
    cmd.mem_op  = tcw_pkg::MEM_NONE;
    cmd.cur_op  = tcw_pkg::CUR_NONE;
    cmd.ptr_op  = tcw_pkg::PTR_HOLD;
    cmd.emit    = 1'b0;

    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          has_req_nxt = 1'b1;
          state_nxt   = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        priority if (sts.is_read) begin
          if (sts.addr_ok) begin
            cmd.mem_op = tcw_pkg::MEM_RD_REQ;
            state_nxt  = tcw_pkg::ST_RDWAIT;
          end else begin
            cmd.emit  = 1'b1;
            state_nxt = tcw_pkg::ST_IDLE;
          end
        end else if (sts.is_clr) begin
          cmd.ptr_op = tcw_pkg::PTR_ZERO;
          cmd.cur_op = tcw_pkg::CUR_HOME;
          state_nxt  = tcw_pkg::ST_CLEAR;
        end else if (sts.is_bs) begin
          if (sts.col_zero) begin
            cmd.emit  = 1'b1;
            state_nxt = tcw_pkg::ST_IDLE;
          end else begin
            cmd.mem_op = tcw_pkg::MEM_PUT;
            state_nxt  = tcw_pkg::ST_UNDER;
          end
        end else begin
          cmd.mem_op = tcw_pkg::MEM_PUT;
          cmd.cur_op = tcw_pkg::CUR_STEP;
          state_nxt  = tcw_pkg::ST_CHECK;
        end
      end
      tcw_pkg::ST_RDWAIT: begin
        cmd.emit  = 1'b1;
        state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_UNDER: begin
        cmd.mem_op = tcw_pkg::MEM_UNDER;
        cmd.cur_op = tcw_pkg::CUR_STEP;
        state_nxt  = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_CHECK: begin
        if (sts.row_over) begin
          cmd.ptr_op = tcw_pkg::PTR_ZERO;
          state_nxt  = tcw_pkg::ST_SCR_RD;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_SCR_RD: begin
        cmd.mem_op = tcw_pkg::MEM_RD_SCR;
        state_nxt  = tcw_pkg::ST_SCR_WR;
      end
      tcw_pkg::ST_SCR_WR: begin
        cmd.mem_op = tcw_pkg::MEM_WR_SCR;
        if (sts.ptr_scr_last) begin
          cmd.ptr_op = tcw_pkg::PTR_BOTTOM;
          state_nxt  = tcw_pkg::ST_BLANK;
        end else begin
          cmd.ptr_op = tcw_pkg::PTR_INC;
          state_nxt  = tcw_pkg::ST_SCR_RD;
        end
      end
      tcw_pkg::ST_BLANK: begin
        cmd.mem_op = tcw_pkg::MEM_BLANK;
        if (sts.ptr_last) begin
          cmd.cur_op = tcw_pkg::CUR_BOTTOM;
          state_nxt  = tcw_pkg::ST_DONE;
        end else begin
          cmd.ptr_op = tcw_pkg::PTR_INC;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        cmd.mem_op = tcw_pkg::MEM_ZERO;
        if (sts.ptr_last) begin
          state_nxt = has_req_r ? tcw_pkg::ST_DONE : tcw_pkg::ST_IDLE;
        end else begin
          cmd.ptr_op = tcw_pkg::PTR_INC;
        end
      end
      tcw_pkg::ST_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase

    if (cmd.emit) begin
      has_req_nxt = 1'b0;
    end
  end

  assign busy = (state_r != tcw_pkg::ST_IDLE);

endmodule

`default_nettype wire

// File: src/tcw_dp.sv
`default_nettype none

module tcw_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tcw_pkg::in_t  in_req,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_wdata,
  input  wire tcw_pkg::cmd_t cmd,
  output tcw_pkg::sts_t      sts,
  output tcw_pkg::out_t      out_res,
  output logic               out_valid
);

  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;

  logic [15:0] mem [tcw_pkg::CELLS];
  logic [15:0] rd_q;

  tcw_pkg::in_t  req_r;
  tcw_pkg::out_t out_r, out_nxt;
  logic          out_valid_r;
  logic [7:0]    attr_r, attr_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;

  logic [ADDR_W-1:0] pos, req_addr;
  logic [15:0]       blank_cell, put_cell;
  logic              we;
  logic [ADDR_W-1:0] wa, ra;
  logic [15:0]       wd;

  assign pos        = ADDR_W'(32'(row_r) * tcw_pkg::COLUMNS + 32'(col_r));
  assign req_addr   = ADDR_W'(req_r.cell_addr);
  assign blank_cell = {attr_r, tcw_pkg::CODE_SPACE};
  assign put_cell   = (sts.is_bs || sts.is_nl) ? blank_cell : {attr_r, req_r.char_code};

  // status back to the controller
  assign sts.is_read      = (req_r.op == tcw_pkg::OP_READ);
  assign sts.addr_ok      = (32'(req_r.cell_addr) < tcw_pkg::CELLS);
  assign sts.is_bs        = (req_r.char_code == tcw_pkg::CODE_BS);
  assign sts.is_nl        = (req_r.char_code == tcw_pkg::CODE_NL);
  assign sts.is_clr       = (req_r.char_code == tcw_pkg::CODE_CLR);
  assign sts.col_zero     = (col_r == '0);
  assign sts.row_over     = (row_r == ROW_W'(tcw_pkg::ROWS));
  assign sts.ptr_scr_last = (ptr_r == ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS - 1));
  assign sts.ptr_last     = (ptr_r == ADDR_W'(tcw_pkg::CELLS - 1));

  // screen port selection: one write and one read per cycle
  always_comb begin
    we = 1'b0;
    wa = ptr_r;
    wd = '0;
    ra = ptr_r;
    unique case (cmd.mem_op)
      tcw_pkg::MEM_PUT: begin
        we = 1'b1;
        wa = pos;
        wd = put_cell;
      end
      tcw_pkg::MEM_UNDER: begin
        we = 1'b1;
        wa = pos - ADDR_W'(1);
        wd = {attr_r, tcw_pkg::CODE_UNDER};
      end
      tcw_pkg::MEM_ZERO: begin
        we = 1'b1;
      end
      tcw_pkg::MEM_BLANK: begin
        we = 1'b1;
        wd = blank_cell;
      end
      tcw_pkg::MEM_RD_REQ: begin
        ra = req_addr;
      end
      tcw_pkg::MEM_RD_SCR: begin
        ra = ptr_r + ADDR_W'(tcw_pkg::COLUMNS);
      end
      tcw_pkg::MEM_WR_SCR: begin
        we = 1'b1;
        wd = rd_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  // cursor update
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    unique case (cmd.cur_op)
      tcw_pkg::CUR_STEP: begin
        priority if (sts.is_bs) begin
          col_nxt = col_r - COL_W'(1);
        end else if (sts.is_nl || col_r == COL_W'(tcw_pkg::COLUMNS - 1)) begin
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      tcw_pkg::CUR_HOME: begin
        col_nxt = '0;
        row_nxt = '0;
      end
      tcw_pkg::CUR_BOTTOM: begin
        col_nxt = '0;
        row_nxt = ROW_W'(tcw_pkg::ROWS - 1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (cmd.ptr_op)
      tcw_pkg::PTR_ZERO:   ptr_nxt = '0;
      tcw_pkg::PTR_BOTTOM: ptr_nxt = ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
      tcw_pkg::PTR_INC:    ptr_nxt = ptr_r + ADDR_W'(1);
      default:             ptr_nxt = ptr_r;
    endcase
  end

  assign attr_nxt = cfg_we ? cfg_wdata : attr_r;

  always_comb begin
    out_nxt.read_data  = (sts.is_read && sts.addr_ok) ? rd_q : 16'h0000;
    out_nxt.cursor_col = 7'(col_r);
    out_nxt.cursor_row = 5'(row_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= tcw_pkg::ATTR_RESET;
      col_r       <= '0;
      row_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      attr_r      <= attr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_res   = out_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: src/text_console_cell_writer_unit.sv
`default_nettype none

// Text console cell writer. A request is taken when start is high and busy is
// low; exactly one result comes back, shown on out_res for a single cycle with
// out_valid high, and the receiver has no way to hold it off, so it must take
// it on that cycle. A read passes through EXEC and RDWAIT, a printable or
// newline put through EXEC and CHECK, a backspace through EXEC, UNDER and
// DONE; an ignored backspace or out-of-range read is answered from EXEC. A
// new request is taken only once the last one is done. A put that runs past
// the last row scrolls the screen, reading each moved cell and writing it one
// row up through the read and write ports of the cell memory, then blanking
// the bottom row. A clear-screen sweeps one cell per cycle. After reset the
// same sweep runs (with busy high) before the first request is taken; the
// attribute register can be written at any time through cfg_we/cfg_wdata.
`include "assert_macros.svh"

module text_console_cell_writer_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // request channel
  input  wire logic         start,
  output logic              busy,
  input  wire tcw_pkg::in_t in_req,
  // result channel
  output logic              out_valid,
  output tcw_pkg::out_t     out_res,
  // attribute register
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_wdata
);

  tcw_pkg::cmd_t cmd;   // controller -> datapath
  tcw_pkg::sts_t sts;   // datapath -> controller
  logic          cursor_on_screen;

  // Sequencer: decodes the request, walks scroll/clear sweeps.
  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Cell memory, cursor, sweep pointer, attribute and result register.
  tcw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_res   (out_res),
    .out_valid (out_valid)
  );

  assign cursor_on_screen = (32'(out_res.cursor_col) < tcw_pkg::COLUMNS) &&
                            (32'(out_res.cursor_row) < tcw_pkg::ROWS);

  // A result only shows once the sequencer is back at rest.
  `ASSERT_CLK(a_result_idle, out_valid |-> !busy, "result strobe while busy")
  // An accepted request makes the block busy on the next cycle.
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted request not busy")
  // Strobe is a single-cycle pulse per request.
  `ASSERT_ALWAYS(a_strobe_pulse, out_valid |=> !out_valid, "result strobe held")
  // Reported cursor lies on the screen.
  `ASSERT_CLK(a_cursor_range, out_valid |-> cursor_on_screen, "cursor off screen")

endmodule

`default_nettype wire

// File: verif/tb_text_console_cell_writer_unit.sv
`default_nettype none

module tb_text_console_cell_writer_unit;

  // Longest legal quiet stretch is a scroll or the power-up clear
  // sweep; the limit leaves ample margin over either.
  localparam int STALL_LIMIT = 20000;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  tcw_pkg::in_t  in_req;
  logic          out_valid;
  tcw_pkg::out_t out_res;
  logic          cfg_we;
  logic [7:0]    cfg_wdata;

  text_console_cell_writer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow console: screen, cursor and attribute as the DUT should hold them
  // ---------------------------------------------------------------------
  logic [15:0] shadow_screen [tcw_pkg::CELLS];
  int unsigned shadow_col;
  int unsigned shadow_row;
  logic [7:0]  shadow_attr;

  tcw_pkg::out_t expected_results [$];
  tcw_pkg::out_t oldest_expected;
  int            mismatch_count = 0;
  int            stall_cycles   = 0;

  function automatic logic [15:0] attr_cell(logic [7:0] code);
    return {shadow_attr, code};
  endfunction

  function automatic void reset_shadow();
    foreach (shadow_screen[i]) shadow_screen[i] = '0;
    shadow_col  = 0;
    shadow_row  = 0;
    shadow_attr = tcw_pkg::ATTR_RESET;
  endfunction

  // Rows 1..ROWS-1 move up, the bottom row goes blank, cursor to its start.
  function automatic void scroll_shadow_up();
    for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLUMNS; i++)
      shadow_screen[i] = shadow_screen[i + tcw_pkg::COLUMNS];
    for (int i = tcw_pkg::CELLS - tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++)
      shadow_screen[i] = attr_cell(tcw_pkg::CODE_SPACE);
    shadow_col = 0;
    shadow_row = tcw_pkg::ROWS - 1;
  endfunction

  // Applies one request to the shadow console and returns the result it
  // must produce.
  function automatic tcw_pkg::out_t predict_console_step(tcw_pkg::in_t req);
    tcw_pkg::out_t res;
    int            pos;
    res = '0;
    pos = shadow_row * tcw_pkg::COLUMNS + shadow_col;
    if (req.op == tcw_pkg::OP_PUT) begin
      if (req.char_code == tcw_pkg::CODE_BS) begin
        // backspace at column zero leaves everything alone
        if (shadow_col != 0) begin
          shadow_screen[pos]     = attr_cell(tcw_pkg::CODE_SPACE);
          shadow_screen[pos - 1] = attr_cell(tcw_pkg::CODE_UNDER);
          shadow_col--;
        end
      end else if (req.char_code == tcw_pkg::CODE_NL) begin
        shadow_screen[pos] = attr_cell(tcw_pkg::CODE_SPACE);
        shadow_col = 0;
        shadow_row++;
      end else if (req.char_code == tcw_pkg::CODE_CLR) begin
        foreach (shadow_screen[i]) shadow_screen[i] = '0;
        shadow_col = 0;
        shadow_row = 0;
      end else begin
        shadow_screen[pos] = attr_cell(req.char_code);
        shadow_col++;
      end
      if (shadow_col >= tcw_pkg::COLUMNS) begin
        shadow_col = 0;
        shadow_row++;
      end
      if (shadow_row >= tcw_pkg::ROWS) scroll_shadow_up();
    end else if (req.cell_addr < tcw_pkg::CELLS) begin
      res.read_data = shadow_screen[req.cell_addr];
    end
    res.cursor_col = 7'(shadow_col);
    res.cursor_row = 5'(shadow_row);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking: every strobe must match the oldest pending request
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (t=%0t)", what, got, want, $time);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'(out_res), 0);
      end else begin
        oldest_expected = expected_results.pop_front();
        if (out_res.read_data !== oldest_expected.read_data)
          report_mismatch("read_data", 32'(out_res.read_data),
                          32'(oldest_expected.read_data));
        if (out_res.cursor_col !== oldest_expected.cursor_col)
          report_mismatch("cursor_col", 32'(out_res.cursor_col),
                          32'(oldest_expected.cursor_col));
        if (out_res.cursor_row !== oldest_expected.cursor_row)
          report_mismatch("cursor_row", 32'(out_res.cursor_row),
                          32'(oldest_expected.cursor_row));
      end
    end
  end

  // Watchdog: any accept on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Request driving
  // ---------------------------------------------------------------------
  // Drives at the falling edge and holds until busy is low at a rising edge.
  // start stays high on return so back-to-back requests need no re-raise.
  task automatic send_request(tcw_pkg::in_t req);
    @(negedge clk);
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_console_step(req));
  endtask

  task automatic put_code(logic [7:0] code);
    tcw_pkg::in_t req;
    req.op        = tcw_pkg::OP_PUT;
    req.char_code = code;
    req.cell_addr = 11'($urandom_range(2047));
    send_request(req);
  endtask

  task automatic read_cell(logic [10:0] addr);
    tcw_pkg::in_t req;
    req.op        = tcw_pkg::OP_READ;
    req.char_code = 8'($urandom_range(255));
    req.cell_addr = addr;
    send_request(req);
  endtask

  // Per-cycle idle chance, so gaps land on every phase of the DUT's work.
  task automatic sender_pause(int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Hold off until all results are back and the DUT is idle.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_attribute(logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    shadow_attr = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly running text: printables with newlines, backspaces and reads
  // mixed in; clear-screen is rare so the cursor reaches the bottom and
  // scrolls often.
  function automatic tcw_pkg::in_t make_text_request();
    tcw_pkg::in_t req;
    int           pick;
    req.op        = tcw_pkg::OP_PUT;
    req.char_code = 8'($urandom_range(255));
    req.cell_addr = 11'($urandom_range(2047));
    pick = $urandom_range(999);
    if (pick < 2) begin
      req.char_code = tcw_pkg::CODE_CLR;
    end else if (pick < 100) begin
      req.char_code = tcw_pkg::CODE_NL;
    end else if (pick < 160) begin
      req.char_code = tcw_pkg::CODE_BS;
    end else if (pick < 370) begin
      req.op = tcw_pkg::OP_READ;
      // half the reads look at the cursor row, where the action is
      if ($urandom_range(1))
        req.cell_addr = 11'(shadow_row * tcw_pkg::COLUMNS +
                            $urandom_range(tcw_pkg::COLUMNS - 1));
    end
    return req;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Screen comes up cleared; reads past the last cell return zero.
  task automatic test_reset_state();
    read_cell(11'd0);
    read_cell(11'(tcw_pkg::CELLS - 1));
    read_cell(11'(tcw_pkg::CELLS));
    read_cell(11'h7FF);
  endtask

  // Every control code plus printable extremes, at the reset attribute.
  task automatic test_put_codes();
    put_code(tcw_pkg::CODE_BS);   // ignored at column zero
    put_code(8'h00);              // zero is printable
    put_code(8'hFF);
    put_code(8'h41);
    put_code(tcw_pkg::CODE_BS);   // blank here, underscore one to the left
    read_cell(11'd0);
    read_cell(11'd1);
    read_cell(11'd2);
    read_cell(11'd3);
    put_code(tcw_pkg::CODE_NL);   // blanks cursor cell, next line start
    put_code(8'h7F);
    read_cell(11'd2);
    read_cell(11'(tcw_pkg::COLUMNS));
    put_code(tcw_pkg::CODE_CLR);
    read_cell(11'd0);
    read_cell(11'(tcw_pkg::COLUMNS));
  endtask

  task automatic test_random_text(int count, int idle_pct);
    for (int n = 0; n < count; n++) begin
      sender_pause(idle_pct);
      if ($urandom_range(99) == 0) wait_drained();
      send_request(make_text_request());
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    reset_shadow();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_put_codes();

    wait_drained();
    write_attribute(8'hFF);
    test_random_text(350, 38);

    wait_drained();
    write_attribute(8'h00);
    test_random_text(350, 54);

    wait_drained();
    write_attribute(8'($urandom_range(1, 254)));
    test_random_text(350, 0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+src
src/tcw_pkg.sv
src/tcw_ctrl.sv
src/tcw_dp.sv
src/text_console_cell_writer_unit.sv
verif/tb_text_console_cell_writer_unit.sv
